[rtl/core/fpfa_pkg.sv]
// Shared types and constants for the fixed partition fit allocator.
// Holds the request and response word layouts, operation and policy codes,
// and the register map. No dependencies.
`default_nettype none

package fpfa_pkg;

	// Default sizing of the partition table.
	localparam int PARTS_DEF     = 16;
	localparam int SIZE_BITS_DEF = 16;

	// Fixed widths of the word fields and registers.
	localparam int SLOT_W   = 4;
	localparam int AMOUNT_W = 16;
	localparam int MODE_W   = 2;
	localparam int NPART_W  = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// Reset values of the configuration registers.
	localparam logic [MODE_W-1:0]  FIT_MODE_RST  = 2'd0;
	localparam logic [NPART_W-1:0] NUM_PARTS_RST = 5'd8;

	// Operation codes carried in a request word.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Placement policies; the unused code behaves as first fit.
	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	// Register indexes, taken from byte address bit 2.
	localparam logic REG_FIT_MODE  = 1'b0;
	localparam logic REG_NUM_PARTS = 1'b1;

	// Request word.
	typedef struct packed {
		logic                op;
		logic [SLOT_W-1:0]   slot;
		logic [AMOUNT_W-1:0] amount;
	} req_t;

	// Response word.
	typedef struct packed {
		logic                granted;
		logic [SLOT_W-1:0]   chosen_partition;
		logic [AMOUNT_W-1:0] left_over;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/fixed_partition_fit_allocator_unit.sv]
// A load word goes from acceptance straight to the completion state and on to the response
// register; an allocate word sweeps n entries, where n is num_partitions limited to PARTS,
// then passes the drain and completion states (a word with n of zero goes as a load does).
// One word at a time, as the table memory has one read port and is swept one entry per cycle.
// Reset: valid bits for every entry are cleared at once, so the whole table reads as zero
// straight after reset; registers return to first fit and 8 partitions. Depends on fpfa_pkg.
`default_nettype none

module fixed_partition_fit_allocator_unit #(
	parameter int PARTS     = fpfa_pkg::PARTS_DEF,
	parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Request channel.
	input  wire                          req_valid,
	output logic                         req_stall,
	input  wire fpfa_pkg::req_t          req,
	// Response channel.
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output fpfa_pkg::rsp_t               rsp,
	// Configuration port.
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [fpfa_pkg::APB_AW-1:0]   paddr,
	input  wire [fpfa_pkg::APB_DW-1:0]   pwdata,
	output logic [fpfa_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	localparam int PW = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int CW = $clog2(PARTS + 1);
	localparam int XW = (CW > fpfa_pkg::NPART_W) ? CW : fpfa_pkg::NPART_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [fpfa_pkg::MODE_W-1:0]   fit_mode_q;
	logic [fpfa_pkg::NPART_W-1:0]  num_parts_q;

	logic                          req_acc;
	logic                          cfg_wr;
	logic [CW-1:0]                 act_cnt;
	logic                          last_rd;
	logic                          fin_go;
	logic                          grant;

	logic [SIZE_BITS-1:0]          amt_q;
	logic [PW-1:0]                 rd_idx_q;
	logic                          rd_vld_s1;
	logic [SIZE_BITS-1:0]          rdata_s1;
	logic                          ent_vld_s1;
	logic [SIZE_BITS-1:0]          ent_val;
	logic                          take;

	logic                          found_q;
	logic [PW-1:0]                 best_idx_q;
	logic [SIZE_BITS-1:0]          best_val_q;

	logic [SIZE_BITS-1:0]          mem [PARTS];
	logic [PARTS-1:0]              vld_q;
	logic                          mem_we;
	logic [PW-1:0]                 mem_wa;
	logic [SIZE_BITS-1:0]          mem_wd;

	logic                          rsp_valid_q;
	fpfa_pkg::rsp_t                rsp_q;

	// Configuration registers: written on the access phase, read back at once.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q  <= fpfa_pkg::FIT_MODE_RST;
			num_parts_q <= fpfa_pkg::NUM_PARTS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fpfa_pkg::REG_FIT_MODE:  fit_mode_q  <= pwdata[fpfa_pkg::MODE_W-1:0];
				fpfa_pkg::REG_NUM_PARTS: num_parts_q <= pwdata[fpfa_pkg::NPART_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fpfa_pkg::REG_FIT_MODE:  prdata = fpfa_pkg::APB_DW'(fit_mode_q);
			fpfa_pkg::REG_NUM_PARTS: prdata = fpfa_pkg::APB_DW'(num_parts_q);
			default:                 prdata = '0;
		endcase
	end

	// Number of entries swept, with the register limited to the table depth.
	always_comb begin
		if (XW'(num_parts_q) > XW'(PARTS)) begin
			act_cnt = CW'(PARTS);
		end else begin
			act_cnt = CW'(num_parts_q);
		end
	end

	// Handshake and sequencing terms.
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign last_rd   = (CW'(rd_idx_q) + CW'(1)) == act_cnt;
	assign fin_go    = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign grant     = found_q && (amt_q <= best_val_q);

	// Sequencer: one word at a time, the sweep issuing one read per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.op == fpfa_pkg::OP_ALLOC && act_cnt != '0) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (last_rd) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Read address counter and the flag marking read data in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (req_acc) begin
				rd_idx_q <= '0;
			end else if (state_q == S_SCAN) begin
				rd_idx_q <= rd_idx_q + PW'(1);
			end
		end
	end

	// The requested amount is held for the whole sweep.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			amt_q <= SIZE_BITS'(req.amount);
		end
	end

	// Table writes: a load at acceptance, a granted allocate at completion. The sequencer
	// never overlaps a write with the sweep, so no forwarding is needed.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = best_idx_q;
		mem_wd = best_val_q - amt_q;
		if (req_acc && req.op == fpfa_pkg::OP_LOAD) begin
			mem_we = 32'(req.slot) < 32'(PARTS);
			mem_wa = PW'(req.slot);
			mem_wd = SIZE_BITS'(req.amount);
		end else if (fin_go && grant) begin
			mem_we = 1'b1;
		end
	end

	// Free size memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_s1   <= mem[rd_idx_q];
		ent_vld_s1 <= vld_q[rd_idx_q];
	end

	// Per-entry valid bits; an entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[mem_wa] <= 1'b1;
		end
	end

	// Policy compare on each entry as it returns from the memory.
	assign ent_val = ent_vld_s1 ? rdata_s1 : '0;

	always_comb begin
		case (fit_mode_q)
			fpfa_pkg::FIT_BEST:  take = (amt_q <= ent_val) && (!found_q || ent_val < best_val_q);
			fpfa_pkg::FIT_WORST: take = !found_q || ent_val > best_val_q;
			default:             take = (amt_q <= ent_val) && !found_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (req_acc) begin
			found_q <= 1'b0;
		end else if (rd_vld_s1 && take) begin
			found_q <= 1'b1;
		end
	end

	// The entry on the read data lags the read counter by one entry, so its index is
	// rebuilt from rd_idx_q.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && take) begin
			best_idx_q <= rd_idx_q - PW'(1);
			best_val_q <= ent_val;
		end
	end

	// Output register; a refused request gives an all-zero response word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rsp_q.granted          <= grant;
			rsp_q.chosen_partition <= grant ? fpfa_pkg::SLOT_W'(best_idx_q) : '0;
			rsp_q.left_over        <= grant ? fpfa_pkg::AMOUNT_W'(best_val_q - amt_q) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The sweep never reads past the active entries.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CW'(rd_idx_q) < act_cnt)
		else $error("sweep address beyond active partitions");

	// A response is raised only on leaving the completion state.
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("response raised outside completion");

	// A refused request reports no partition and no size.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.granted |-> rsp_q.chosen_partition == '0 && rsp_q.left_over == '0)
		else $error("refused response carries a partition or size");

	// A grant in flight always has a fitting candidate.
	a_grant_fits: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && grant |-> found_q && best_val_q >= amt_q)
		else $error("grant without a fitting partition");

endmodule

`default_nettype wire
